@@ rtl/multi_channel_step_sequencer_assert.svh @@
// Assertion macros shared by the step sequencer checker.
`ifndef MULTI_CHANNEL_STEP_SEQUENCER_ASSERT_SVH
`define MULTI_CHANNEL_STEP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MCSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("step sequencer check failed");

// Next-cycle implication, disabled while reset is held.
`define MCSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("step sequencer check failed");

`endif

@@ rtl/mcss_pkg.sv @@
// Shared types and constants of the multi-channel step sequencer.
`default_nettype none

package mcss_pkg;

  localparam int CHANNELS = 3;
  localparam int STEPS    = 16;  // power of two: step index is the low address bits
  localparam int CH_W     = 2;
  localparam int POS_W    = $clog2(STEPS);
  localparam int DEPTH    = CHANNELS * STEPS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int DATA_W   = 8;
  localparam int LEN_W    = 5;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(STEPS);

  // Operation codes; unused codes act as read only
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_REWIND   = 3'd1;
  localparam logic [2:0] OP_WR_GATE  = 3'd2;
  localparam logic [2:0] OP_WR_CV    = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [CH_W-1:0]   channel;
    logic              direction;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] gate;
    logic [DATA_W-1:0] cv;
    logic [POS_W-1:0]  position;
    logic              channel_valid;
  } out_item_t;

  // Write request into the pattern memories
  typedef struct packed {
    logic              gate_en;
    logic              cv_en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  // Read request into the pattern memories
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

`default_nettype wire

@@ rtl/mcss_step_mem.sv @@
// Gate and cv pattern memories with per-entry valid bits for reset values.
`default_nettype none

module mcss_step_mem (
  input  wire                         clk,
  input  wire                         rst_n,
  input  mcss_pkg::mem_wr_t           wr,
  input  mcss_pkg::mem_rd_t           rd,
  output logic [mcss_pkg::DATA_W-1:0] rd_gate,
  output logic [mcss_pkg::DATA_W-1:0] rd_cv
);
  import mcss_pkg::*;

  logic [DATA_W-1:0] gate_mem [DEPTH];
  logic [DATA_W-1:0] cv_mem   [DEPTH];
  logic [DEPTH-1:0]  gate_vld_r;
  logic [DEPTH-1:0]  cv_vld_r;

  logic [DATA_W-1:0] rd_gate_raw_r;
  logic [DATA_W-1:0] rd_cv_raw_r;
  logic              rd_gate_vld_r;
  logic              rd_cv_vld_r;
  logic              rd_step0_r;

  // Memory arrays: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr.gate_en) begin
      gate_mem[wr.addr] <= wr.data;
    end
    if (wr.cv_en) begin
      cv_mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_gate_raw_r <= gate_mem[rd.addr];
      rd_cv_raw_r   <= cv_mem[rd.addr];
      rd_gate_vld_r <= gate_vld_r[rd.addr];
      rd_cv_vld_r   <= cv_vld_r[rd.addr];
      rd_step0_r    <= (rd.addr[POS_W-1:0] == '0);
    end
  end

  // Written-since-reset flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_vld_r <= '0;
      cv_vld_r   <= '0;
    end else begin
      if (wr.gate_en) begin
        gate_vld_r[wr.addr] <= 1'b1;
      end
      if (wr.cv_en) begin
        cv_vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  // Unwritten entries read as their reset value: gate is 1 at step 0
  assign rd_gate = rd_gate_vld_r ? rd_gate_raw_r : DATA_W'(rd_step0_r);
  assign rd_cv   = rd_cv_vld_r   ? rd_cv_raw_r   : '0;

endmodule

`default_nettype wire

@@ rtl/multi_channel_step_sequencer.sv @@
// Top level of the three-channel step sequencer.
//
// Input channel (in_valid / in_stall / in_item): one item names a channel and
// an operation (tick, rewind, write gate, write cv, read). Every item yields
// exactly one result on the output channel (out_valid / out_stall / out_item)
// with the gate, cv and position of that channel after the operation; a
// channel number out of range yields zeros with channel_valid clear.
// The position update and any memory write happen at acceptance, the
// pattern memories are read in S_READ and the output register loads in
// S_LOAD once it is free. One item is in work at a time, while a finished
// result may wait in the output register.
// A stalled result holds out_item; the block then holds a following item in
// its last stage and raises in_stall until the output register frees up.
// cfg_data writes pattern_length (always ready); write it only while idle.
// Reset: positions go to 0, pattern_length to 16, all cv entries read 0 and
// all gate entries read 0 except step 0 of each channel, which reads 1.
`default_nettype none

module multi_channel_step_sequencer (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  mcss_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  wire                        out_stall,
  output mcss_pkg::out_item_t        out_item,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [mcss_pkg::LEN_W-1:0]  cfg_data
);
  import mcss_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LOAD} state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  pos_r [CHANNELS];
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  logic              chv_r, chv_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              in_acc;
  logic              ch_ok;
  logic [CH_W-1:0]   ch_idx;
  logic [POS_W-1:0]  len_m1;
  logic [POS_W-1:0]  pos_cur;
  logic [POS_W-1:0]  pos_new;
  logic              out_free;
  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [DATA_W-1:0] rd_gate;
  logic [DATA_W-1:0] rd_cv;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Channel select; an invalid channel touches nothing
  assign ch_ok   = (int'(in_item.channel) < CHANNELS);
  assign ch_idx  = ch_ok ? in_item.channel : '0;
  assign pos_cur = pos_r[ch_idx];

  // Effective length minus one, clamped to 1..STEPS
  always_comb begin
    if (len_r == '0) begin
      len_m1 = '0;
    end else if (int'(len_r) > STEPS) begin
      len_m1 = POS_W'(STEPS - 1);
    end else begin
      len_m1 = POS_W'(len_r - 1'b1);
    end
  end

  // Next position
  always_comb begin
    pos_new = pos_cur;
    case (in_item.op)
      OP_TICK: begin
        if (in_item.direction) begin
          pos_new = (pos_cur == '0) ? len_m1 : pos_cur - 1'b1;
        end else begin
          pos_new = (pos_cur >= len_m1) ? '0 : pos_cur + 1'b1;
        end
      end
      OP_REWIND: pos_new = '0;
      default:   pos_new = pos_cur;
    endcase
  end

  // Memory write at the current step on acceptance
  always_comb begin
    mem_wr.gate_en = in_acc && ch_ok && (in_item.op == OP_WR_GATE);
    mem_wr.cv_en   = in_acc && ch_ok && (in_item.op == OP_WR_CV);
    mem_wr.addr    = ADDR_W'(ch_idx * STEPS) + ADDR_W'(pos_cur);
    mem_wr.data    = in_item.value;
  end

  // Read in S_READ, the cycle after the write, so no forwarding is needed
  assign mem_rd.en   = (state_r == S_READ);
  assign mem_rd.addr = addr_r;

  mcss_step_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_gate (rd_gate),
    .rd_cv   (rd_cv)
  );

  // Sequencer control and output register
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    addr_nxt      = addr_r;
    opos_nxt      = opos_r;
    chv_nxt       = chv_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_valid && cfg_ready) begin
      len_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          addr_nxt  = ADDR_W'(ch_idx * STEPS) + ADDR_W'(pos_new);
          opos_nxt  = pos_new;
          chv_nxt   = ch_ok;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (chv_r) begin
            out_item_nxt.gate          = rd_gate;
            out_item_nxt.cv            = rd_cv;
            out_item_nxt.position      = opos_r;
            out_item_nxt.channel_valid = 1'b1;
          end else begin
            out_item_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc && ch_ok) begin
        pos_r[ch_idx] <= pos_new;
      end
    end
    addr_r     <= addr_nxt;
    opos_r     <= opos_nxt;
    chv_r      <= chv_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ rtl/mcss_checker.sv @@
// Port-level checks of the step sequencer, bound to the top level.
`default_nettype none
`include "multi_channel_step_sequencer_assert.svh"

module mcss_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input mcss_pkg::in_item_t   in_item,
  input wire                  out_valid,
  input wire                  out_stall,
  input mcss_pkg::out_item_t  out_item
);
  import mcss_pkg::*;

  logic in_acc;
  logic in_busy;

  assign in_acc  = in_valid && !in_stall;
  assign in_busy = in_stall || (in_item.op == OP_READ && 1'b0);

  // A stalled result stays offered
  `MCSS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // One item in work at a time: acceptance closes the input
  `MCSS_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall)

  // Out-of-range channels report all zeros
  `MCSS_ASSERT_IMP(a_invalid_zero, out_valid && !out_item.channel_valid,
    out_item.gate == '0 && out_item.cv == '0 && out_item.position == '0)

  // A fresh result only comes out of an item that was in work
  `MCSS_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_busy))

endmodule

bind multi_channel_step_sequencer mcss_checker u_mcss_checker (.*);

`default_nettype wire
